// File: rtl/ess_pkg.sv
`default_nettype none

package ess_pkg;

   // Group capacity and the widths that follow from it.
   localparam int MAX_MODELS = 16;
   localparam int CNT_W      = $clog2(MAX_MODELS + 1);
   localparam int TEMP_W     = 16;
   localparam int REG_W      = 16;
   localparam int SUM_W      = TEMP_W + CNT_W;
   localparam int SQ_W       = 2 * TEMP_W + CNT_W - 2;

   // n * sumsq and sum * sum, and the clamped difference of the two.
   localparam int NSQ_W  = SQ_W + CNT_W;
   localparam int SUM2_W = 2 * SUM_W;
   localparam int D_W    = NSQ_W;

   // Radicand is the difference shifted up by 16 bits; kept even for the root.
   localparam int FRAC_W = 16;
   localparam int RAD_W  = 2 * ((D_W + FRAC_W + 1) / 2);
   localparam int ROOT_W = RAD_W / 2;

   // Root times scale, plus the rounding term, then shifted down by 16.
   localparam int PROD_W = ROOT_W + REG_W;
   localparam int X_W    = PROD_W + 1;
   localparam int Y_W    = X_W - FRAC_W;

   // Shared divider width covers both the mean and the sigma dividends.
   localparam int DIV_W  = (Y_W > SUM_W + 1) ? Y_W : SUM_W + 1;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_AGREE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA_SCALE     = 2'd1;

   localparam logic [REG_W-1:0] AGREE_THRESHOLD_RESET = 16'd384;
   localparam logic [REG_W-1:0] SIGMA_SCALE_RESET     = 16'd640;

   typedef struct packed {
      logic [15:0]        date_tag;
      logic signed [15:0] temperature;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0]        group_tag;
      logic [4:0]         value_count;
      logic signed [15:0] mean_value;
      logic [15:0]        value_range;
      logic [15:0]        scaled_sigma;
      logic               agree;
      logic               dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_MULT,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_SCALE,
      ST_SIGMA_GO,
      ST_SIGMA_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic acc_en;
      logic acc_clear;
      logic mul_load;
      logic div_start_mean;
      logic mean_store;
      logic sqrt_start;
      logic scale_load;
      logic div_start_sigma;
      logic sigma_store;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/ess_divider.sv
`default_nettype none

module ess_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ess_pkg::DIV_W-1:0] dividend,
   input  wire logic [ess_pkg::CNT_W-1:0] divisor,
   output logic      [ess_pkg::DIV_W-1:0] quotient,
   output logic                           done
);
   import ess_pkg::*;

   // Restoring division, one quotient bit per cycle, MSB first.
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    shifted;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = (shifted >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DCNT_W'(DIV_W);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? CNT_W'(shifted - {1'b0, dsr_ff}) : shifted[CNT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: rtl/ess_sqrt.sv
`default_nettype none

module ess_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ess_pkg::RAD_W-1:0]  radicand,
   output logic      [ess_pkg::ROOT_W-1:0] root,
   output logic                            done
);
   import ess_pkg::*;

   // Digit-by-digit integer square root, one result bit per cycle.
   logic [RAD_W-1:0] val_ff, val_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      done_in = done_ff;
      if (start) begin
         val_in  = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
         done_in = 1'b0;
      end else if (bit_ff != '0) begin
         if (val_ff >= trial) begin
            val_in = val_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == RAD_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      res_ff <= res_in;
   end

   assign root = res_ff[ROOT_W-1:0];
   assign done = done_ff;

endmodule

`default_nettype wire

// File: rtl/ess_datapath.sv
`default_nettype none

module ess_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ess_pkg::cmd_type              cmd,
   output ess_pkg::sts_type                   sts,
   input  wire ess_pkg::req_type              req_data,
   output ess_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_write_en,
   input  wire logic [ess_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ess_pkg::REG_W-1:0]     csr_wdata
);
   import ess_pkg::*;

   logic [REG_W-1:0]         thr_ff, thr_in;
   logic [REG_W-1:0]         scale_ff, scale_in;

   logic [15:0]              tag_ff, tag_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic signed [TEMP_W-1:0] min_ff, min_in;
   logic signed [TEMP_W-1:0] max_ff, max_in;
   logic                     ovf_ff, ovf_in;

   logic [NSQ_W-1:0]         nsq_ff;
   logic [SUM2_W-1:0]        ssq_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [DIV_W-1:0]         mean_q_ff;
   logic [DIV_W-1:0]         sigma_q_ff;
   rsp_type                  rsp_ff;

   logic signed [2*TEMP_W-1:0] tsq;
   logic signed [SUM2_W-1:0]   ssq;
   logic signed [SUM2_W:0]     diff;
   logic [D_W-1:0]             dval;
   logic [RAD_W-1:0]           radicand;
   logic [SUM_W-1:0]           abs_sum;
   logic [X_W-1:0]             xval;
   logic [DIV_W-1:0]           div_dividend;
   logic                       div_start;
   logic [DIV_W-1:0]           quotient;
   logic [ROOT_W-1:0]          root;
   logic signed [TEMP_W:0]     span;
   logic [15:0]                mean_mag;
   rsp_type                    rsp_in;

   // Configuration registers.
   always_comb begin
      thr_in   = thr_ff;
      scale_in = scale_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_AGREE_THRESHOLD: thr_in   = csr_wdata;
            CSR_SIGMA_SCALE:     scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Group accumulators.
   always_comb begin
      tsq    = req_data.temperature * req_data.temperature;
      tag_in = tag_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      min_in = min_ff;
      max_in = max_ff;
      ovf_in = ovf_ff;
      if (cmd.acc_clear) begin
         cnt_in = '0;
         sum_in = '0;
         sq_in  = '0;
         min_in = {1'b0, {(TEMP_W-1){1'b1}}};
         max_in = {1'b1, {(TEMP_W-1){1'b0}}};
         ovf_in = 1'b0;
      end else if (cmd.acc_en) begin
         tag_in = req_data.date_tag;
         if (cnt_ff < CNT_W'(MAX_MODELS)) begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_ff + SUM_W'(req_data.temperature);
            sq_in  = sq_ff + SQ_W'(unsigned'(tsq));
            if (req_data.temperature < min_ff) begin
               min_in = req_data.temperature;
            end
            if (req_data.temperature > max_ff) begin
               max_in = req_data.temperature;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Closing arithmetic feeding the shared divider and the root unit.
   always_comb begin
      ssq     = sum_ff * sum_ff;
      diff    = $signed({1'b0, SUM2_W'(nsq_ff)}) - $signed({1'b0, ssq_ff});
      dval    = diff[SUM2_W] ? '0 : diff[D_W-1:0];
      radicand = RAD_W'({dval, {FRAC_W{1'b0}}});
      abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      xval    = X_W'(prod_ff) + (X_W'(cnt_ff) << (FRAC_W - 1));
      div_start = cmd.div_start_mean | cmd.div_start_sigma;
      if (cmd.div_start_sigma) begin
         div_dividend = DIV_W'(xval[X_W-1:FRAC_W]);
      end else begin
         div_dividend = DIV_W'(abs_sum) + DIV_W'(cnt_ff >> 1);
      end
   end

   ess_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .quotient (quotient),
      .done     (sts.div_done)
   );

   ess_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (radicand),
      .root     (root),
      .done     (sts.sqrt_done)
   );

   // Result assembly.
   always_comb begin
      span     = $signed({max_ff[TEMP_W-1], max_ff}) - $signed({min_ff[TEMP_W-1], min_ff});
      mean_mag = mean_q_ff[15:0];
      rsp_in.group_tag   = tag_ff;
      rsp_in.value_count = 5'(cnt_ff);
      if (cnt_ff == '0) begin
         rsp_in.mean_value  = '0;
         rsp_in.value_range = '0;
      end else begin
         rsp_in.mean_value  = sum_ff[SUM_W-1] ? -mean_mag : mean_mag;
         rsp_in.value_range = span[15:0];
      end
      if (cnt_ff <= CNT_W'(1)) begin
         rsp_in.scaled_sigma = '0;
      end else if (sigma_q_ff > DIV_W'(16'hFFFF)) begin
         rsp_in.scaled_sigma = 16'hFFFF;
      end else begin
         rsp_in.scaled_sigma = sigma_q_ff[15:0];
      end
      rsp_in.agree   = (rsp_in.value_range < thr_ff);
      rsp_in.dropped = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= AGREE_THRESHOLD_RESET;
         scale_ff <= SIGMA_SCALE_RESET;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         min_ff   <= {1'b0, {(TEMP_W-1){1'b1}}};
         max_ff   <= {1'b1, {(TEMP_W-1){1'b0}}};
         ovf_ff   <= 1'b0;
      end else begin
         thr_ff   <= thr_in;
         scale_ff <= scale_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         ovf_ff   <= ovf_in;
      end
      tag_ff <= tag_in;
      if (cmd.mul_load) begin
         nsq_ff <= cnt_ff * sq_ff;
         ssq_ff <= unsigned'(ssq);
      end
      if (cmd.scale_load) begin
         prod_ff <= root * scale_ff;
      end
      if (cmd.mean_store) begin
         mean_q_ff <= quotient;
      end
      if (cmd.sigma_store) begin
         sigma_q_ff <= quotient;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/ess_ctrl.sv
`default_nettype none

module ess_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ess_pkg::cmd_type      cmd,
   input  wire ess_pkg::sts_type sts
);
   import ess_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT:    if (req_valid && req_last) state_in = ST_MULT;
         ST_MULT:       state_in = ST_MEAN_GO;
         ST_MEAN_GO:    state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT:  if (sts.div_done) state_in = ST_ROOT_GO;
         ST_ROOT_GO:    state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT:  if (sts.sqrt_done) state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_SIGMA_GO;
         ST_SIGMA_GO:   state_in = ST_SIGMA_WAIT;
         ST_SIGMA_WAIT: if (sts.div_done) state_in = ST_EMIT;
         ST_EMIT:       if (out_free) state_in = ST_COLLECT;
         default:       state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_ready  = 1'b1;
            cmd.acc_en = req_valid;
         end
         ST_MULT:       cmd.mul_load = 1'b1;
         ST_MEAN_GO:    cmd.div_start_mean = 1'b1;
         ST_MEAN_WAIT:  cmd.mean_store = sts.div_done;
         ST_ROOT_GO:    cmd.sqrt_start = 1'b1;
         ST_ROOT_WAIT:  ;
         ST_SCALE:      cmd.scale_load = 1'b1;
         ST_SIGMA_GO:   cmd.div_start_sigma = 1'b1;
         ST_SIGMA_WAIT: cmd.sigma_store = sts.div_done;
         ST_EMIT: begin
            cmd.out_load  = out_free;
            cmd.acc_clear = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/ensemble_spread_statistics.sv
// Ensemble spread statistics over date groups.
//
// Requests arrive on req_valid/req_ready/req_data, one model temperature
// (signed Q8.8) each, tagged with a date. A request with last set closes the
// group. Requests without last are taken one per clock cycle while a group
// is collected and give no response. A closing request gives one response
// on rsp_valid/rsp_ready/rsp_data with the tag, count, rounded mean, range,
// scaled sigma and flags. Values beyond the group capacity are discarded
// and flag the response. After a closing request, and before rsp_valid
// rises, one shared restoring divider runs twice (one quotient bit a cycle,
// for the mean and for sigma) and the square root unit takes one bit a cycle.
// req_ready is low for that whole time. The finished response sits in an
// output register, so a new group is collected while the receiver stalls;
// only the next closing group waits until that register is free.
// The csr_ port writes agree_threshold (index 0) and sigma_scale (index 1).
// Reset, synchronous and active high, restores the register defaults
// (1.5 and 2.5), clears the group and drops any pending response.
`default_nettype none

module ensemble_spread_statistics (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire ess_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output ess_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_write_en,
   input  wire logic [ess_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ess_pkg::REG_W-1:0]     csr_wdata
);
   import ess_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: collection, products, mean division, root, scaling, sigma division, output.
   ess_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Accumulators, configuration, arithmetic units and the response register.
   ess_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

// Self-checking bench for the ensemble spread statistics block.
//
// A short table of hand-picked requests runs first. After that come random
// date groups, under several register settings and three patterns of
// sender and receiver idling. Every accepted request is folded into a local
// copy of the group statistics. Each closing request leaves one expected
// response in a queue, and a monitor compares every accepted response with
// the oldest entry, field by field.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ess_pkg::*;

   // This margin covers any work that a closing request may still have in
   // flight after the last response.
   localparam int SETTLE_CYCLES = 160;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 88;

   // Indexes past the two registers; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   // How the temperatures of one random group are spread out.
   typedef enum int {
      SPREAD_WIDE,
      SPREAD_TIGHT,
      SPREAD_EXTREME
   } spread_kind;

   // One row of the directed part. Where typed is set, result holds the
   // response worked out by hand for a closing request.
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } stim_row;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   // Local copy of the group accumulators and of the two registers.
   int              grp_count;
   longint          grp_sum;
   longint unsigned grp_sumsq;
   int              grp_min;
   int              grp_max;
   bit              grp_dropped;
   logic [REG_W-1:0] agree_threshold_q = AGREE_THRESHOLD_RESET;
   logic [REG_W-1:0] sigma_scale_q     = SIGMA_SCALE_RESET;

   rsp_type pending_stats[$];
   stim_row stim_rows[$];

   int error_count    = 0;
   int cycle_count    = 0;
   int readings_sent  = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   ensemble_spread_statistics u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A hang anywhere ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate set for the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Floor of the square root, one result bit per pass, high bits first.
   function automatic longint unsigned root_floor(input longint unsigned radicand);
      longint unsigned rest  = radicand;
      longint unsigned root  = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > rest)
         probe >>= 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic void clear_group();
      grp_count   = 0;
      grp_sum     = 0;
      grp_sumsq   = 0;
      grp_min     = 32767;
      grp_max     = -32768;
      grp_dropped = 1'b0;
   endfunction

   // Folds one accepted request into the group. A closing request turns the
   // group into its expected response and starts a fresh group.
   function automatic void fold_reading(input req_type r);
      int              reading;
      int              span;
      longint          n;
      longint          mean;
      longint          diff;
      longint unsigned nu;
      longint unsigned root;
      longint unsigned sigma;
      rsp_type         want;

      reading = int'(r.temperature);
      if (grp_count < MAX_MODELS) begin
         grp_count++;
         grp_sum   += longint'(reading);
         grp_sumsq += longint'(reading * reading);
         if (reading < grp_min) grp_min = reading;
         if (reading > grp_max) grp_max = reading;
      end else begin
         // The group is full: the value is lost but its last flag still counts.
         grp_dropped = 1'b1;
      end
      if (!r.last)
         return;

      n     = longint'(grp_count);
      nu    = longint'(grp_count);
      mean  = 0;
      span  = 0;
      sigma = 0;
      if (n > 0) begin
         // Round half away from zero, on the magnitude.
         if (grp_sum >= 0)
            mean = (grp_sum + n / 2) / n;
         else
            mean = -((-grp_sum + n / 2) / n);
         span = grp_max - grp_min;
      end
      if (n > 1) begin
         // sigma * n = sqrt(n * sumsq - sum^2); the root carries 8 extra
         // fraction bits, and the scale and the division by n follow with
         // rounding.
         diff = n * longint'(grp_sumsq) - grp_sum * grp_sum;
         if (diff < 0) diff = 0;
         root  = root_floor(longint'(diff) << 16);
         sigma = (root * sigma_scale_q + 64'd32768 * nu) / (64'd65536 * nu);
         if (sigma > 65535) sigma = 65535;
      end

      want.group_tag    = r.date_tag;
      want.value_count  = n[4:0];
      want.mean_value   = mean[15:0];
      want.value_range  = span[15:0];
      want.scaled_sigma = sigma[15:0];
      want.agree        = (span < agree_threshold_q);
      want.dropped      = grp_dropped;
      pending_stats.insert(pending_stats.size(), want);
      clear_group();
   endfunction

   // Compares one accepted response with the oldest expectation.
   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (pending_stats.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("unexpected response: tag %h count %0d", got.group_tag,
                     got.value_count);
      end else begin
         want = pending_stats.pop_front();
         if (got.group_tag !== want.group_tag || got.value_count !== want.value_count ||
             got.mean_value !== want.mean_value || got.value_range !== want.value_range ||
             got.scaled_sigma !== want.scaled_sigma || got.agree !== want.agree ||
             got.dropped !== want.dropped) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("mismatch expected: tag %h n %0d mean %0d range %0d sigma %0d agree %b dropped %b",
                        want.group_tag, want.value_count, want.mean_value,
                        want.value_range, want.scaled_sigma, want.agree, want.dropped);
               $display("         actual:   tag %h n %0d mean %0d range %0d sigma %0d agree %b dropped %b",
                        got.group_tag, got.value_count, got.mean_value,
                        got.value_range, got.scaled_sigma, got.agree, got.dropped);
            end
         end
      end
   endtask

   // Response monitor. Signals are read right after the edge, before the
   // block's own updates land, so they hold the values seen at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_response(rsp_data);
   end

   // Presents one request and returns at the edge that accepts it. Valid is
   // left high, so the next request can follow without a gap.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      fold_reading(item);
      readings_sent++;
   endtask

   // Stops sending until every expected response has come back. It always
   // waits on the clock before returning, so valid is never lowered and raised at once.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_stats.size() != 0);
   endtask

   // Register writes happen only with the block idle.
   task automatic program_registers(input logic [REG_W-1:0] threshold,
                                    input logic [REG_W-1:0] scale,
                                    input logic [CSR_IDX_W-1:0] spare);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_AGREE_THRESHOLD;
      csr_wdata    <= threshold;
      @(posedge clock);
      csr_index    <= CSR_SIGMA_SCALE;
      csr_wdata    <= scale;
      @(posedge clock);
      // Unused index with junk data; both registers must keep their values.
      csr_index    <= spare;
      csr_wdata    <= REG_W'($urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
      agree_threshold_q = threshold;
      sigma_scale_q     = scale;
   endtask

   // One random date group. Most groups fit the capacity; about one in ten
   // overruns it, so the dropped flag and the count limit get exercised.
   task automatic send_group();
      int          size;
      int          pick;
      spread_kind  spread;
      logic [15:0] tag;
      logic [15:0] base;
      req_type     item;

      size   = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
      spread = spread_kind'($urandom_range(2));
      tag    = 16'($urandom);
      base   = 16'($urandom);
      for (int i = 0; i < size; i++) begin
         case (spread)
            SPREAD_WIDE: begin
               item.temperature = 16'($urandom);
            end
            SPREAD_TIGHT: begin
               // Spread under three degrees, so the agree flag goes both ways.
               item.temperature = 16'(base + $urandom_range(767) - 384);
            end
            default: begin
               pick = $urandom_range(2);
               item.temperature = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : base;
            end
         endcase
         // Only the closing request's tag matters; the others vary now and then.
         item.date_tag = ($urandom_range(15) == 0) ? 16'($urandom) : tag;
         item.last     = (i == size - 1);
         send_request(item);
      end
   endtask

   function automatic void add_row(input logic [15:0] tag, input logic [15:0] reading,
                                   input bit last_flag, input bit typed,
                                   input rsp_type result);
      stim_row row;
      row.item.date_tag    = tag;
      row.item.temperature = reading;
      row.item.last        = last_flag;
      row.typed            = typed;
      row.result           = result;
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   initial begin
      logic [REG_W-1:0] threshold;
      logic [REG_W-1:0] scale;
      int               phase_end;

      clear_group();

      // Single-value groups: the mean is the value itself and sigma is zero.
      add_row(16'h0000, 16'h0000, 1'b1, 1'b1,
              {16'h0000, 5'd1, 16'h0000, 16'd0, 16'd0, 1'b1, 1'b0});
      add_row(16'hFFFF, 16'h7FFF, 1'b1, 1'b1,
              {16'hFFFF, 5'd1, 16'h7FFF, 16'd0, 16'd0, 1'b1, 1'b0});
      add_row(16'h1234, 16'h8000, 1'b1, 1'b1,
              {16'h1234, 5'd1, 16'h8000, 16'd0, 16'd0, 1'b1, 1'b0});
      // Both extremes: full range, sigma saturates; the closing tag is used.
      add_row(16'hAAAA, 16'h8000, 1'b0, 1'b0, '0);
      add_row(16'h5555, 16'h7FFF, 1'b1, 1'b0, '0);
      // A negative sum that lands on a half rounds away from zero.
      add_row(16'h00F0, 16'hFFFF, 1'b0, 1'b0, '0);
      add_row(16'h00F0, 16'hFFFE, 1'b1, 1'b0, '0);
      // A full group of equal values, then one more that is dropped but
      // still closes the group.
      for (int i = 0; i < MAX_MODELS; i++)
         add_row(16'h0F0F, 16'h0100, 1'b0, 1'b0, '0);
      add_row(16'h0F0F, 16'h8000, 1'b1, 1'b1,
              {16'h0F0F, 5'd16, 16'h0100, 16'd0, 16'd0, 1'b1, 1'b1});

      // Reset is applied once, at the start of the run.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // First idling pattern: sender idles lightly, receiver stalls heavily.
      send_idle_pct = 28;
      recv_idle_pct = 82;
      foreach (stim_rows[i]) begin
         send_request(stim_rows[i].item);
         if (stim_rows[i].typed)
            pending_stats[pending_stats.size() - 1] = stim_rows[i].result;
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               threshold = '0;
               scale     = '0;
            end
            1: begin
               threshold = '1;
               scale     = '1;
            end
            3: begin
               threshold = 16'd256;
               scale     = 16'd256;
            end
            5: begin
               threshold = AGREE_THRESHOLD_RESET;
               scale     = SIGMA_SCALE_RESET;
            end
            default: begin
               threshold = REG_W'($urandom);
               scale     = REG_W'($urandom);
            end
         endcase
         program_registers(threshold, scale, phase[0] ? CSR_SPARE_HIGH : CSR_SPARE_LOW);

         // The sender and receiver swap roles midway, then both run flat out.
         if (phase >= 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (phase >= 2) begin
            send_idle_pct = 82;
            recv_idle_pct = 28;
         end

         phase_end = readings_sent + PHASE_ITEMS;
         while (readings_sent < phase_end) begin
            // Now and then the sender holds back until the block has answered
            // everything it was given.
            if ($urandom_range(19) == 0)
               drain_responses();
            send_group();
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_stats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
